// ===== rtl/mha_pkg.sv =====
// ============================================================================
// mha_pkg
// Shared widths, types and the arctangent table of the heading pipeline.
// ============================================================================
package mha_pkg;

   // Raw sensor word, register and result widths
   localparam int RAW_W     = 16;
   localparam int DECL_W    = 16;
   localparam int HEAD_W    = 18;

   // CORDIC vector: 16-bit sample scaled by 256, plus headroom for gain
   localparam int XY_W      = 27;
   // Angle accumulator, units of 1/32768 degree, signed
   localparam int Z_W       = 26;
   // Wrapped angle, 0 .. 360 degrees exclusive, unsigned
   localparam int ZW_W      = 24;
   // Heading before declination, 0 .. 46079
   localparam int H_W       = 16;
   localparam int SHIFT_W   = 5;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int NUM_STEPS    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   localparam int DEG_UNITS    = 32768;
   localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(180 * DEG_UNITS);
   localparam logic signed [Z_W-1:0] FULL_TURN_Z = Z_W'(360 * DEG_UNITS);
   localparam logic [ZW_W-1:0]       ROUND_HALF  = ZW_W'(128);
   localparam logic [H_W-1:0]        FULL_TURN_H = H_W'(46080);

   // Beat carried between CORDIC stages
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
   } vec_type;

   // atan(2^-i) in degrees times 32768, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [SHIFT_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = Z_W'(1474560);
         5'd1:    val = Z_W'(870484);
         5'd2:    val = Z_W'(459940);
         5'd3:    val = Z_W'(233473);
         5'd4:    val = Z_W'(117189);
         5'd5:    val = Z_W'(58652);
         5'd6:    val = Z_W'(29333);
         5'd7:    val = Z_W'(14667);
         5'd8:    val = Z_W'(7334);
         5'd9:    val = Z_W'(3667);
         5'd10:   val = Z_W'(1833);
         5'd11:   val = Z_W'(917);
         5'd12:   val = Z_W'(458);
         5'd13:   val = Z_W'(229);
         5'd14:   val = Z_W'(115);
         5'd15:   val = Z_W'(57);
         5'd16:   val = Z_W'(29);
         5'd17:   val = Z_W'(14);
         5'd18:   val = Z_W'(7);
         5'd19:   val = Z_W'(4);
         5'd20:   val = Z_W'(2);
         5'd21:   val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/mha_req_if.sv =====
// ============================================================================
// mha_req_if
// Sample channel: one beat carries the raw X and Y words.
// ============================================================================
interface mha_req_if;
   logic                        valid;
   logic                        ready;
   logic [mha_pkg::RAW_W-1:0]   raw_x;
   logic [mha_pkg::RAW_W-1:0]   raw_y;

   modport source (output valid, output raw_x, output raw_y, input ready);
   modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

// ===== rtl/mha_rsp_if.sv =====
// ============================================================================
// mha_rsp_if
// Result channel: one beat carries the heading.
// ============================================================================
interface mha_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mha_pkg::HEAD_W-1:0]  heading_value;

   modport source (output valid, output heading_value, input ready);
   modport sink   (input valid, input heading_value, output ready);
endinterface

// ===== rtl/mha_csr_if.sv =====
// ============================================================================
// mha_csr_if
// Register write channel: one beat carries the declination offset.
// ============================================================================
interface mha_csr_if;
   logic                               valid;
   logic                               ready;
   logic signed [mha_pkg::DECL_W-1:0]  declination_offset;

   modport source (output valid, output declination_offset, input ready);
   modport sink   (input valid, input declination_offset, output ready);
endinterface

// ===== rtl/mha_prep.sv =====
// ============================================================================
// mha_prep
// Entry stage: sign-extend and scale the sample, fold the left half plane.
// ============================================================================
module mha_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_i,
   output logic                          ready_o,
   input  logic [mha_pkg::RAW_W-1:0]     raw_x_i,
   input  logic [mha_pkg::RAW_W-1:0]     raw_y_i,
   output logic                          valid_o,
   input  logic                          ready_i,
   output mha_pkg::vec_type              data_o
);

   logic                valid_ff;
   mha_pkg::vec_type    data_ff;
   mha_pkg::vec_type    data_in;
   logic signed [mha_pkg::XY_W-1:0] sx;
   logic signed [mha_pkg::XY_W-1:0] sy;

   // Scale by 256 with sign extension
   assign sx = {{(mha_pkg::XY_W-mha_pkg::RAW_W-8){raw_x_i[mha_pkg::RAW_W-1]}}, raw_x_i, 8'h00};
   assign sy = {{(mha_pkg::XY_W-mha_pkg::RAW_W-8){raw_y_i[mha_pkg::RAW_W-1]}}, raw_y_i, 8'h00};

   // Negate the vector for x < 0 and start the angle at half a turn
   always_comb begin
      data_in.zero = (raw_x_i == '0) && (raw_y_i == '0);
      if (raw_x_i[mha_pkg::RAW_W-1]) begin
         data_in.x = -sx;
         data_in.y = -sy;
         data_in.z = mha_pkg::HALF_TURN_Z;
      end else begin
         data_in.x = sx;
         data_in.y = sy;
         data_in.z = '0;
      end
   end

   assign ready_o = !valid_ff || ready_i;

   // Advance when the next stage takes the held beat or the slot is empty
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

// ===== rtl/mha_cordic_stage.sv =====
// ============================================================================
// mha_cordic_stage
// One vectoring CORDIC micro-rotation with its pipeline register.
// ============================================================================
module mha_cordic_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mha_pkg::SHIFT_W-1:0]        shift_amt,
   input  logic                               valid_i,
   output logic                               ready_o,
   input  mha_pkg::vec_type                   data_i,
   output logic                               valid_o,
   input  logic                               ready_i,
   output mha_pkg::vec_type                   data_o
);

   logic                valid_ff;
   mha_pkg::vec_type    data_ff;
   mha_pkg::vec_type    data_in;
   logic signed [mha_pkg::XY_W-1:0] dx;
   logic signed [mha_pkg::XY_W-1:0] dy;
   logic signed [mha_pkg::Z_W-1:0]  ang;

   // Arithmetic shifts floor, matching the reference rounding
   assign dx  = data_i.y >>> shift_amt;
   assign dy  = data_i.x >>> shift_amt;
   assign ang = mha_pkg::atan_entry(shift_amt);

   // Rotate toward the x axis
   always_comb begin
      data_in.zero = data_i.zero;
      if (!data_i.y[mha_pkg::XY_W-1]) begin
         data_in.x = data_i.x + dx;
         data_in.y = data_i.y - dy;
         data_in.z = data_i.z + ang;
      end else begin
         data_in.x = data_i.x - dx;
         data_in.y = data_i.y + dy;
         data_in.z = data_i.z - ang;
      end
   end

   assign ready_o = !valid_ff || ready_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

// ===== rtl/mha_finish.sv =====
// ============================================================================
// mha_finish
// Two stages: wrap the angle into one turn, then round and add declination.
// ============================================================================
module mha_finish (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [mha_pkg::DECL_W-1:0]  decl_i,
   input  logic                               valid_i,
   output logic                               ready_o,
   input  mha_pkg::vec_type                   data_i,
   output logic                               valid_o,
   input  logic                               ready_i,
   output logic signed [mha_pkg::HEAD_W-1:0]  heading_o
);

   logic                              wrap_valid_ff;
   logic                              wrap_ready;
   logic [mha_pkg::ZW_W-1:0]          wrap_ff;
   logic [mha_pkg::ZW_W-1:0]          wrap_in;
   logic                              zero_ff;
   logic signed [mha_pkg::Z_W-1:0]    z_adj;

   logic                              out_valid_ff;
   logic signed [mha_pkg::HEAD_W-1:0] heading_ff;
   logic signed [mha_pkg::HEAD_W-1:0] heading_in;
   logic [mha_pkg::ZW_W-1:0]          rounded;
   logic [mha_pkg::H_W-1:0]           h_raw;
   logic [mha_pkg::H_W-1:0]           h_wrap;

   // Wrap: add a turn when negative, drop one when at or past a full turn
   always_comb begin
      if (data_i.z[mha_pkg::Z_W-1]) begin
         z_adj = data_i.z + mha_pkg::FULL_TURN_Z;
      end else if (data_i.z >= mha_pkg::FULL_TURN_Z) begin
         z_adj = data_i.z - mha_pkg::FULL_TURN_Z;
      end else begin
         z_adj = data_i.z;
      end
      wrap_in = z_adj[mha_pkg::ZW_W-1:0];
   end

   assign wrap_ready = !out_valid_ff || ready_i;
   assign ready_o    = !wrap_valid_ff || wrap_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
      end else if (ready_o) begin
         wrap_valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         wrap_ff <= wrap_in;
         zero_ff <= data_i.zero;
      end
   end

   // Round half up to 1/128 degree, fold a rounded full turn, add declination
   always_comb begin
      rounded = wrap_ff + mha_pkg::ROUND_HALF;
      h_raw   = rounded[mha_pkg::ZW_W-1:8];
      if (h_raw >= mha_pkg::FULL_TURN_H) begin
         h_wrap = h_raw - mha_pkg::FULL_TURN_H;
      end else begin
         h_wrap = h_raw;
      end
      if (zero_ff) begin
         h_wrap = '0;
      end
      heading_in = $signed({2'b00, h_wrap})
                 + {{(mha_pkg::HEAD_W-mha_pkg::DECL_W){decl_i[mha_pkg::DECL_W-1]}}, decl_i};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (wrap_ready) begin
         out_valid_ff <= wrap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wrap_ready && wrap_valid_ff) begin
         heading_ff <= heading_in;
      end
   end

   assign valid_o   = out_valid_ff;
   assign heading_o = heading_ff;

endmodule

// ===== rtl/magnetic_heading_atan2_unit.sv =====
// ============================================================================
// magnetic_heading_atan2_unit
// Compass heading from raw magnetometer X/Y words by a pipelined CORDIC.
// ============================================================================
//
//   channel   dir   fields                    meaning
//   req_bus   in    raw_x, raw_y              raw sensor words, two's complement
//   rsp_bus   out   heading_value             heading + declination, 1/128 deg
//   csr_bus   in    declination_offset        declination, signed, 1/128 deg
//
// One sample enters per cycle while the pipe is not stalled. Its stages:
// one entry stage, one register per CORDIC micro-rotation, a wrap stage and a
// rounding/declination stage. Reset clears all valid bits and the declination.
// Each stage holds its beat while the stage after it is full and stalled, so a
// stall backs up one stage at a time and empty stages keep taking samples.
// The register write is taken every cycle.
//
module magnetic_heading_atan2_unit (
   input  logic       clock,
   input  logic       reset,
   mha_req_if.sink    req_bus,
   mha_rsp_if.source  rsp_bus,
   mha_csr_if.sink    csr_bus
);

   logic signed [mha_pkg::DECL_W-1:0] decl_ff;

   logic                stage_vld [0:mha_pkg::NUM_STEPS];
   logic                stage_rdy [0:mha_pkg::NUM_STEPS];
   mha_pkg::vec_type    stage_dat [0:mha_pkg::NUM_STEPS];

   // Declination register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
      end else if (csr_bus.valid) begin
         decl_ff <= csr_bus.declination_offset;
      end
   end

   // Entry stage
   mha_prep u_prep (
      .clock   (clock),
      .reset   (reset),
      .valid_i (req_bus.valid),
      .ready_o (req_bus.ready),
      .raw_x_i (req_bus.raw_x),
      .raw_y_i (req_bus.raw_y),
      .valid_o (stage_vld[0]),
      .ready_i (stage_rdy[0]),
      .data_o  (stage_dat[0])
   );

   // CORDIC micro-rotations, one register each
   for (genvar i = 0; i < mha_pkg::NUM_STEPS; i++) begin : g_step
      mha_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (mha_pkg::SHIFT_W'(i)),
         .valid_i   (stage_vld[i]),
         .ready_o   (stage_rdy[i]),
         .data_i    (stage_dat[i]),
         .valid_o   (stage_vld[i+1]),
         .ready_i   (stage_rdy[i+1]),
         .data_o    (stage_dat[i+1])
      );
   end

   // Wrap, round and add declination
   mha_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .decl_i    (decl_ff),
      .valid_i   (stage_vld[mha_pkg::NUM_STEPS]),
      .ready_o   (stage_rdy[mha_pkg::NUM_STEPS]),
      .data_i    (stage_dat[mha_pkg::NUM_STEPS]),
      .valid_o   (rsp_bus.valid),
      .ready_i   (rsp_bus.ready),
      .heading_o (rsp_bus.heading_value)
   );

`ifndef SYNTHESIS
   // An empty output stage opens the whole ready chain back to the input
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("input stalled while output stage is empty");

   // No result beat right after reset
   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result beat presented right after reset");
`endif

endmodule

// ===== bench/magnetic_heading_atan2_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// magnetic_heading_atan2_unit_tb
// Self-checking bench for the CORDIC compass heading pipeline. Raw X/Y words
// go in through a randomly paced sender. Headings are taken by a randomly
// stalling receiver, with one long hold-off that backs the pipe up. Each
// heading is compared against a bit-exact predictor run over several
// declination settings, the extremes among them.
// ============================================================================
module magnetic_heading_atan2_unit_tb;

   // Predicts headings and holds the ones still owed by the pipeline
   class heading_scoreboard;
      typedef struct {
         logic [mha_pkg::RAW_W-1:0]         raw_x;
         logic [mha_pkg::RAW_W-1:0]         raw_y;
         logic signed [mha_pkg::HEAD_W-1:0] heading;
      } owed_heading_type;

      owed_heading_type                  owed_q[$];
      logic signed [mha_pkg::DECL_W-1:0] declination;
      int                                errors;

      function new();
         declination = '0;
         errors      = 0;
      endfunction

      // atan(2^-k) in degrees, scaled by 32768
      function longint atan_z(int k);
         longint v;
         case (k)
            0:  v = 1474560;
            1:  v = 870484;
            2:  v = 459940;
            3:  v = 233473;
            4:  v = 117189;
            5:  v = 58652;
            6:  v = 29333;
            7:  v = 14667;
            8:  v = 7334;
            9:  v = 3667;
            10: v = 1833;
            11: v = 917;
            12: v = 458;
            13: v = 229;
            14: v = 115;
            15: v = 57;
            16: v = 29;
            17: v = 14;
            18: v = 7;
            19: v = 4;
            20: v = 2;
            21: v = 1;
            default: v = 0;
         endcase
         return v;
      endfunction

      function logic signed [mha_pkg::HEAD_W-1:0] heading_for(
            logic [mha_pkg::RAW_W-1:0] rx,
            logic [mha_pkg::RAW_W-1:0] ry);
         longint vx, vy, ang, hd, sx, sy;
         logic signed [mha_pkg::RAW_W-1:0] srx, sry;
         srx = rx;
         sry = ry;
         vx  = srx;
         vy  = sry;
         ang = 0;
         hd  = 0;
         // Zero vector keeps heading 0
         if (vx != 0 || vy != 0) begin
            vx = vx * 256;
            vy = vy * 256;
            // Fold the left half plane over, starting at 180 degrees
            if (vx < 0) begin
               vx  = -vx;
               vy  = -vy;
               ang = 180 * 32768;
            end
            for (int k = 0; k < mha_pkg::NUM_STEPS; k++) begin
               sx = vy >>> k;
               sy = vx >>> k;
               if (vy >= 0) begin
                  vx  = vx + sx;
                  vy  = vy - sy;
                  ang = ang + atan_z(k);
               end else begin
                  vx  = vx - sx;
                  vy  = vy + sy;
                  ang = ang - atan_z(k);
               end
            end
            // Wrap into one turn, then round to 1/128 degree
            if (ang < 0)
               ang = ang + 360 * 32768;
            if (ang >= 360 * 32768)
               ang = ang - 360 * 32768;
            hd = (ang + 128) / 256;
            if (hd >= 46080)
               hd = hd - 46080;
         end
         hd = hd + longint'(declination);
         return hd[mha_pkg::HEAD_W-1:0];
      endfunction

      function void set_declination(logic signed [mha_pkg::DECL_W-1:0] value);
         declination = value;
      endfunction

      function void note_sample(logic [mha_pkg::RAW_W-1:0] rx,
                                logic [mha_pkg::RAW_W-1:0] ry);
         owed_heading_type e;
         e.raw_x   = rx;
         e.raw_y   = ry;
         e.heading = heading_for(rx, ry);
         owed_q.push_back(e);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_heading(logic signed [mha_pkg::HEAD_W-1:0] got);
         owed_heading_type e;
         if (owed_q.size() == 0) begin
            report_mismatch($sformatf("heading %0d with no sample pending", got));
         end else begin
            e = owed_q.pop_front();
            if (got !== e.heading)
               report_mismatch($sformatf("x=%h y=%h heading %0d, wanted %0d",
                                         e.raw_x, e.raw_y, got, e.heading));
         end
      endtask

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   mha_req_if req_bus ();
   mha_rsp_if rsp_bus ();
   mha_csr_if csr_bus ();

   magnetic_heading_atan2_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   heading_scoreboard board;
   bit                no_idle;
   bit                long_hold_done;
   int                results_seen;

   localparam int LATENCY     = mha_pkg::NUM_STEPS + 3;
   localparam int PHASE_ITEMS = 200;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 150;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Raw word biased toward extremes and small values
   function automatic logic [mha_pkg::RAW_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         5:       return mha_pkg::RAW_W'($urandom_range(0, 8) - 4);
         6:       return ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
         7:       return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         default: return mha_pkg::RAW_W'($urandom);
      endcase
   endfunction

   // Offer one sample; lower valid after it on a gap or at the burst end
   task automatic drive_sample(input logic [mha_pkg::RAW_W-1:0] rx,
                               input logic [mha_pkg::RAW_W-1:0] ry,
                               input bit last);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.raw_x <= rx;
      req_bus.raw_y <= ry;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_sample(rx, ry);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0 || last)
         req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   task automatic write_declination(input logic signed [mha_pkg::DECL_W-1:0] value);
      csr_bus.valid              <= 1'b1;
      csr_bus.declination_offset <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      board.set_declination(value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Random samples, with a sprinkle of zero vectors and on-axis pairs
   task automatic run_random(input int count);
      logic [mha_pkg::RAW_W-1:0] rx, ry;
      int                        r;
      for (int n = 0; n < count; n++) begin
         r  = $urandom_range(0, 39);
         rx = pick_word();
         ry = pick_word();
         if (r == 0) begin
            rx = '0;
            ry = '0;
         end else if (r == 1) begin
            rx = '0;
         end else if (r == 2) begin
            ry = '0;
         end
         drive_sample(rx, ry, n == count - 1);
      end
   endtask

   // Axes, quadrant corners, near-zero and the wrap edge just below 360
   task automatic run_corners();
      logic [31:0] corners [22];
      corners = '{
         {16'h0000, 16'h0000}, {16'h7FFF, 16'h0000}, {16'h8000, 16'h0000},
         {16'h0000, 16'h7FFF}, {16'h0000, 16'h8000}, {16'h7FFF, 16'h7FFF},
         {16'h8000, 16'h8000}, {16'h8000, 16'h7FFF}, {16'h7FFF, 16'h8000},
         {16'hFFFF, 16'h0000}, {16'h0000, 16'hFFFF}, {16'hFFFF, 16'hFFFF},
         {16'h0001, 16'h0000}, {16'h0000, 16'h0001}, {16'h0001, 16'hFFFF},
         {16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h0001}, {16'h8000, 16'h0001},
         {16'h8000, 16'hFFFF}, {16'hFFFF, 16'h0001}, {16'h5555, 16'hAAAA},
         {16'hAAAA, 16'h5555}
      };
      for (int n = 0; n < 22; n++)
         drive_sample(corners[n][31:16], corners[n][15:0], n == 21);
   endtask

   // Receiver: random stalls, plus one long hold-off once HOLD_AT results are seen
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!long_hold_done && results_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // Check each heading beat
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_heading(rsp_bus.heading_value);
         results_seen++;
      end
   end

   // Main sequence
   initial begin
      logic signed [mha_pkg::DECL_W-1:0] decl_list [7];
      board                      = new();
      no_idle                    = 1'b0;
      long_hold_done             = 1'b0;
      results_seen               = 0;
      reset                      = 1'b1;
      req_bus.valid              = 1'b0;
      req_bus.raw_x              = '0;
      req_bus.raw_y              = '0;
      csr_bus.valid              = 1'b0;
      csr_bus.declination_offset = '0;
      decl_list = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd32767, 16'sh8000,
                    mha_pkg::DECL_W'($urandom_range(0, 46080) - 23040),
                    mha_pkg::DECL_W'($urandom_range(0, 46080) - 23040)};

      // Hold reset, then release it
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_declination(decl_list[0]);
      run_corners();
      for (int p = 0; p < 7; p++) begin
         // Change declination only with the pipe empty
         if (p > 0) begin
            wait_drained();
            write_declination(decl_list[p]);
         end
         no_idle = (p == 3);
         run_random(PHASE_ITEMS);
      end
      no_idle = 1'b0;

      // Drain and let the pipe settle
      wait_drained();
      repeat (3 * LATENCY) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
